// ----- sv/swm_pkg.sv -----
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants and controller/datapath command and status types for the
// sliding window median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 32;
  localparam int CFG_BITS        = 7;
  localparam int IN_BITS         = 32;

  typedef struct packed {
    logic accept;     // latch sample, write ring, start insertion
    logic ins_step;   // move larger entry up one slot
    logic put;        // write new sample into its slot, grow window
    logic med_lo;     // read lower middle entry and oldest sample
    logic med_hi;     // read upper middle entry
    logic emit;       // load result register, start search at entry 0
    logic del_step;   // search moves on to next entry
    logic del_found;  // match found, start shifting down
    logic del_shift;  // move next entry down one slot
    logic retire;     // shrink window, advance oldest pointer
  } cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic ins_gt;
    logic ins_at_one;
    logic full_next;
    logic del_last;
    logic del_eq;
    logic sh_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- sv/swm_ctrl.sv -----
// ----------------------------------------------------------------------------
// swm_ctrl
// Sequencer for the median filter: insertion into the sorted store, median
// read-out and removal of the oldest sample; input stalls outside idle.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  swm_pkg::sts_t      sts,
  output swm_pkg::cmd_t      cmd
);
  import swm_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_INS_CMP = 8'b0000_0010,
    S_INS_PUT = 8'b0000_0100,
    S_MED_LO  = 8'b0000_1000,
    S_MED_HI  = 8'b0001_0000,
    S_EMIT    = 8'b0010_0000,
    S_DEL_CMP = 8'b0100_0000,
    S_DEL_SH  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.fill_zero ? S_INS_PUT : S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (sts.ins_gt) begin
          cmd.ins_step = 1'b1;
          state_nxt    = sts.ins_at_one ? S_INS_PUT : S_INS_CMP;
        end else begin
          cmd.put   = 1'b1;
          state_nxt = sts.full_next ? S_MED_LO : S_IDLE;
        end
      end
      S_INS_PUT: begin
        cmd.put   = 1'b1;
        state_nxt = sts.full_next ? S_MED_LO : S_IDLE;
      end
      S_MED_LO: begin
        cmd.med_lo = 1'b1;
        state_nxt  = S_MED_HI;
      end
      S_MED_HI: begin
        cmd.med_hi = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_DEL_CMP;
        end
      end
      S_DEL_CMP: begin
        if (sts.del_last) begin
          cmd.retire = 1'b1;
          state_nxt  = S_IDLE;
        end else if (sts.del_eq) begin
          cmd.del_found = 1'b1;
          state_nxt     = S_DEL_SH;
        end else begin
          cmd.del_step = 1'b1;
        end
      end
      S_DEL_SH: begin
        cmd.del_shift = 1'b1;
        if (sts.sh_last) begin
          cmd.retire = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/swm_dp.sv -----
// ----------------------------------------------------------------------------
// swm_dp
// Datapath: arrival ring, sorted store, window counters, median adder and
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_dp #(
  parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [swm_pkg::IN_BITS-1:0]     in_sample,
  input  wire logic                            cfg_wr_en,
  input  wire logic [swm_pkg::CFG_BITS-1:0]    cfg_wr_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [SAMPLE_BITS:0]                 out_median_x2,
  input  swm_pkg::cmd_t                        cmd,
  output swm_pkg::sts_t                        sts
);
  import swm_pkg::*;

  localparam int AW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int KW   = $clog2(WINDOW_MAX + 1);
  localparam int CMPW = (KW > CFG_BITS) ? KW : CFG_BITS;

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;

  smp_t sorted_mem [WINDOW_MAX];
  smp_t ring_mem   [WINDOW_MAX];

  logic [CFG_BITS-1:0] win_r;
  logic [KW-1:0]       fill_r;
  logic [AW-1:0]       oldest_r;
  logic [AW-1:0]       idx_r;
  smp_t                x_r;
  smp_t                lo_r;
  smp_t                srd_r;
  smp_t                rrd_r;
  logic                out_valid_r;
  logic [SAMPLE_BITS:0] out_data_r;

  smp_t                in_ext;
  logic [CMPW-1:0]     win_ext;
  logic [KW-1:0]       k_eff;
  logic [KW-1:0]       k_m1;
  logic [AW-1:0]       lo_addr;
  logic [AW-1:0]       hi_addr;
  logic [KW:0]         idx_x;
  logic [KW:0]         fill_x;
  logic [KW:0]         wsum;
  logic [KW:0]         wpos_x;
  logic [AW-1:0]       wpos;
  logic [AW-1:0]       oldest_inc;
  logic                s_we;
  logic [AW-1:0]       s_waddr;
  smp_t                s_wdata;
  logic                s_re;
  logic [AW-1:0]       s_raddr;
  logic                out_free;

  assign in_ext  = smp_t'(in_sample[SAMPLE_BITS-1:0]);
  assign win_ext = CMPW'(win_r);

  always_comb begin
    if (win_r == '0) begin
      k_eff = KW'(1);
    end else if (win_ext > CMPW'(WINDOW_MAX)) begin
      k_eff = KW'(WINDOW_MAX);
    end else begin
      k_eff = KW'(win_ext);
    end
  end

  assign k_m1    = k_eff - KW'(1);
  assign lo_addr = AW'(k_m1 >> 1);
  assign hi_addr = AW'(k_eff >> 1);

  assign idx_x  = (KW+1)'(idx_r);
  assign fill_x = (KW+1)'(fill_r);
  assign wsum   = (KW+1)'(oldest_r) + fill_x;
  assign wpos_x = (wsum >= (KW+1)'(WINDOW_MAX)) ? wsum - (KW+1)'(WINDOW_MAX) : wsum;
  assign wpos   = wpos_x[AW-1:0];
  assign oldest_inc = (oldest_r == AW'(WINDOW_MAX - 1)) ? '0 : oldest_r + AW'(1);

  assign out_free = !out_valid_r || !out_stall;

  assign sts.fill_zero  = (fill_r == '0);
  assign sts.ins_gt     = (srd_r > x_r);
  assign sts.ins_at_one = (idx_r == AW'(1));
  assign sts.full_next  = ((fill_x + (KW+1)'(1)) >= (KW+1)'(k_eff));
  assign sts.del_last   = ((idx_x + (KW+1)'(1)) >= fill_x);
  assign sts.del_eq     = (srd_r == rrd_r);
  assign sts.sh_last    = ((idx_x + (KW+1)'(2)) >= fill_x);
  assign sts.out_free   = out_free;

  // sorted store port control
  assign s_we    = cmd.ins_step || cmd.put || cmd.del_shift;
  assign s_waddr = idx_r;
  assign s_wdata = cmd.put ? x_r : srd_r;

  always_comb begin
    s_re    = 1'b0;
    s_raddr = '0;
    if (cmd.accept && !sts.fill_zero) begin
      s_re    = 1'b1;
      s_raddr = AW'(fill_r - KW'(1));
    end else if (cmd.ins_step && !sts.ins_at_one) begin
      s_re    = 1'b1;
      s_raddr = idx_r - AW'(2);
    end else if (cmd.med_lo) begin
      s_re    = 1'b1;
      s_raddr = lo_addr;
    end else if (cmd.med_hi) begin
      s_re    = 1'b1;
      s_raddr = hi_addr;
    end else if (cmd.emit) begin
      s_re    = 1'b1;
      s_raddr = '0;
    end else if (cmd.del_step || cmd.del_found) begin
      s_re    = 1'b1;
      s_raddr = idx_r + AW'(1);
    end else if (cmd.del_shift && !sts.sh_last) begin
      s_re    = 1'b1;
      s_raddr = idx_r + AW'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      sorted_mem[s_waddr] <= s_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (s_re) begin
      srd_r <= sorted_mem[s_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ring_mem[wpos] <= in_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.med_lo) begin
      rrd_r <= ring_mem[oldest_r];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r <= in_ext;
    end
    if (cmd.med_hi) begin
      lo_r <= srd_r;
    end
    if (cmd.emit) begin
      out_data_r <= {lo_r[SAMPLE_BITS-1], lo_r} + {srd_r[SAMPLE_BITS-1], srd_r};
    end
    if (cmd.accept) begin
      idx_r <= AW'(fill_r);
    end else if (cmd.ins_step) begin
      idx_r <= idx_r - AW'(1);
    end else if (cmd.emit) begin
      idx_r <= '0;
    end else if (cmd.del_step || cmd.del_shift) begin
      idx_r <= idx_r + AW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= CFG_BITS'(1);
      fill_r      <= '0;
      oldest_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        win_r    <= cfg_wr_data;
        fill_r   <= '0;
        oldest_r <= '0;
      end else if (cmd.put) begin
        fill_r <= fill_r + KW'(1);
      end else if (cmd.retire) begin
        fill_r   <= fill_r - KW'(1);
        oldest_r <= oldest_inc;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_median_x2 = out_data_r;

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_x <= (KW+1)'(WINDOW_MAX))
    else $error("window fill count out of range");

  a_oldest_range: assert property (@(posedge clk) disable iff (!rst_n)
    (KW+1)'(oldest_r) < (KW+1)'(WINDOW_MAX))
    else $error("oldest pointer out of range");

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> (fill_r == '0) && (oldest_r == '0))
    else $error("window not cleared after config write");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free)
    else $error("result loaded over an untaken transaction");

  a_retire_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.retire |-> (fill_r == k_eff))
    else $error("retire with window not full");
`endif

endmodule

`default_nettype wire

// ----- sv/sliding_window_median.sv -----
// A sample is taken only when idle; in_stall stays high until its insertion
// and, once the window is full, median read-out and removal are done.
// Reset (rst_n low, synchronous) empties the window and sets the window
// size to 1; no clearing pass, ready the cycle after reset.
// ----------------------------------------------------------------------------
// sliding_window_median
// Sliding-window median filter returning twice the median of the last K
// samples, kept in an arrival ring and a sorted store.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_median #(
  parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [swm_pkg::IN_BITS-1:0]  in_sample,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [SAMPLE_BITS:0]              out_median_x2,
  input  wire logic                         cfg_wr_en,
  input  wire logic [swm_pkg::CFG_BITS-1:0] cfg_wr_data
);
  import swm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  swm_dp #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_sample     (in_sample),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_median_x2 (out_median_x2),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

`default_nettype wire
